/* rtl/core/pse_pkg.sv */
// shared types and constants for the precise sleep estimator
// no dependencies
`default_nettype none
package pse_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int USEC_W        = 20;
   localparam int REQ_W         = 24;
   localparam int CNT_W         = 14;
   localparam int TL_W          = 26;
   localparam int M2_W          = 64;
   localparam int STEP_W        = 7;
   localparam int CSR_IDX_W     = 2;

   localparam logic [USEC_W-1:0] FLOOR_RST   = USEC_W'(1000);
   localparam logic [USEC_W-1:0] CLAMP_RST   = USEC_W'(20000);
   localparam logic [CNT_W-1:0]  RESTART_RST = CNT_W'(10000);
   localparam logic [USEC_W-1:0] START_USEC  = USEC_W'(2000);

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART = 2'd2;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_OBSERVE = 1'b1;
   localparam logic ACT_SLEEP  = 1'b0;
   localparam logic ACT_SPIN   = 1'b1;

   typedef enum logic [1:0] {
      MODE_MUL,
      MODE_DIV,
      MODE_SQRT
   } pse_mode_type;

   typedef struct packed {
      logic         start;
      pse_mode_type mode;
   } pse_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL_T,
      ST_DIV_VAR,
      ST_SQRT,
      ST_MUL_R,
      ST_DECIDE
   } pse_state_type;

endpackage
`default_nettype wire

/* rtl/core/pse_iter.sv */
// shared iterative unit: shift-add multiply, restoring divide, digit square root
// one add/subtract per cycle; uses pse_pkg
`default_nettype none
module pse_iter
   import pse_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire  logic                                   clock,
   input  wire  logic                                   reset,
   input  wire  pse_cmd_type                            cmd,
   input  wire  logic [M2_W+FRAC_BITS+(FRAC_BITS%2)-1:0] x_in,
   input  wire  logic [USEC_W+FRAC_BITS-1:0]            b_in,
   output logic                                         done,
   output logic [2*(USEC_W+FRAC_BITS)-1:0]              acc_out,
   output logic [M2_W-1:0]                              q_out
);

   localparam int FIX_W = USEC_W + FRAC_BITS;
   localparam int UW    = 2 * FIX_W;
   localparam int XW    = M2_W + FRAC_BITS + (FRAC_BITS % 2);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   pse_mode_type        mode_ff, mode_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [UW-1:0]       acc_ff, acc_in;
   logic [XW-1:0]       x_ff, x_in_nx;
   logic [M2_W-1:0]     q_ff, q_in;
   logic [FIX_W-1:0]    b_ff, b_in_nx;

   logic [UW-1:0]       opa, opb;
   logic                sub;
   logic [UW:0]         sum_w;
   logic                neg;

   always_comb begin
      opa = '0;
      opb = '0;
      sub = 1'b0;
      case (mode_ff)
         MODE_MUL: begin
            opa = {acc_ff[UW-2:0], 1'b0};
            opb = x_ff[XW-1] ? UW'(b_ff) : '0;
         end
         MODE_DIV: begin
            opa = {acc_ff[UW-2:0], x_ff[XW-1]};
            opb = UW'(b_ff);
            sub = 1'b1;
         end
         MODE_SQRT: begin
            opa = {acc_ff[UW-3:0], x_ff[XW-1:XW-2]};
            opb = UW'({q_ff, 2'b01});
            sub = 1'b1;
         end
         default: begin
            opa = '0;
         end
      endcase
      sum_w = {1'b0, opa} + (sub ? ~{1'b0, opb} : {1'b0, opb}) + (UW+1)'(sub);
      neg   = sub & sum_w[UW];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mode_in  = mode_ff;
      steps_in = steps_ff;
      acc_in   = acc_ff;
      x_in_nx  = x_ff;
      q_in     = q_ff;
      b_in_nx  = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         acc_in  = '0;
         q_in    = '0;
         x_in_nx = x_in;
         b_in_nx = b_in;
         case (cmd.mode)
            MODE_MUL:  steps_in = STEP_W'(FIX_W);
            MODE_DIV:  steps_in = STEP_W'(M2_W);
            MODE_SQRT: steps_in = STEP_W'(XW / 2);
            default:   steps_in = STEP_W'(1);
         endcase
      end else if (busy_ff) begin
         steps_in = steps_ff - STEP_W'(1);
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (mode_ff)
            MODE_MUL: begin
               acc_in  = sum_w[UW-1:0];
               x_in_nx = {x_ff[XW-2:0], 1'b0};
            end
            MODE_DIV: begin
               acc_in  = neg ? opa : sum_w[UW-1:0];
               q_in    = {q_ff[M2_W-2:0], ~neg};
               x_in_nx = {x_ff[XW-2:0], 1'b0};
            end
            default: begin
               acc_in  = neg ? opa : sum_w[UW-1:0];
               q_in    = {q_ff[M2_W-2:0], ~neg};
               x_in_nx = {x_ff[XW-3:0], 2'b00};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff  <= mode_in;
      steps_ff <= steps_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in_nx;
      q_ff     <= q_in;
      b_ff     <= b_in_nx;
   end

   assign done    = done_ff;
   assign acc_out = acc_ff;
   assign q_out   = q_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("start while unit busy");
   a_done_clear: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while unit busy");
   a_steps_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> steps_ff != '0)
      else $error("busy with no steps left");
`endif

endmodule
`default_nettype wire

/* rtl/core/pse_seq.sv */
// sequencer and statistics state of the sleep estimator
// drives pse_iter through the welford update; uses pse_pkg
`default_nettype none
module pse_seq
   import pse_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              req_accept,
   input  wire  logic              op,
   input  wire  logic [REQ_W-1:0]  requested_usec,
   input  wire  logic [USEC_W-1:0] observed_usec,
   input  wire  logic [USEC_W-1:0] floor_usec,
   input  wire  logic [USEC_W-1:0] clamp_usec,
   input  wire  logic [CNT_W-1:0]  restart_after,
   input  wire  logic              out_ready,
   output logic                    idle,
   output logic                    out_load,
   output logic                    action,
   output logic [REQ_W-1:0]        spin_usec,
   output logic [USEC_W-1:0]       estimate_usec
);

   localparam int FIX_W = USEC_W + FRAC_BITS;
   localparam int UW    = 2 * FIX_W;
   localparam int XW    = M2_W + FRAC_BITS + (FRAC_BITS % 2);
   localparam logic [FIX_W-1:0] START_FIX = {START_USEC, {FRAC_BITS{1'b0}}};
   localparam logic [FIX_W-1:0] FIX_MAX   = '1;

   pse_state_type       state_ff, state_in;
   logic [TL_W-1:0]     tl_ff, tl_in;
   logic [FIX_W-1:0]    mean_ff, mean_in;
   logic [M2_W-1:0]     m2_ff, m2_in;
   logic [CNT_W-1:0]    sample_ff, sample_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FIX_W-1:0]    est_ff, est_in;
   logic [FIX_W-1:0]    obs_fx_ff, obs_fx_in;
   logic [FIX_W-1:0]    ad_ff, ad_in;
   logic                dneg_ff, dneg_in;

   pse_cmd_type         cmd;
   logic [XW-1:0]       x_cmd;
   logic [FIX_W-1:0]    b_cmd;
   logic                it_done;
   logic [UW-1:0]       acc;
   logic [M2_W-1:0]     q;

   logic [USEC_W-1:0]   obs;
   logic [FIX_W-1:0]    obs_fx;
   logic [TL_W:0]       tl_sub;
   logic [FIX_W:0]      delta;
   logic [FIX_W-1:0]    qstep, mean_new, ae;
   logic [FIX_W:0]      e_w;
   logic [M2_W:0]       m2_sum;
   logic [M2_W-1:0]     m2_sat;
   logic [M2_W:0]       est_sum;
   logic [FIX_W-1:0]    est_raw, floor_fx;
   logic                restart;
   logic                sleep;

   pse_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .x_in    (x_cmd),
      .b_in    (b_cmd),
      .done    (it_done),
      .acc_out (acc),
      .q_out   (q)
   );

   always_comb begin
      obs      = (observed_usec > clamp_usec) ? clamp_usec : observed_usec;
      obs_fx   = {obs, {FRAC_BITS{1'b0}}};
      tl_sub   = {tl_ff[TL_W-1], tl_ff} - (TL_W+1)'(obs);
      delta    = {1'b0, obs_fx} - {1'b0, mean_ff};
      qstep    = q[FIX_W-1:0];
      mean_new = dneg_ff ? (mean_ff - qstep) : (mean_ff + qstep);
      e_w      = {1'b0, obs_fx_ff} - {1'b0, mean_new};
      ae       = e_w[FIX_W] ? FIX_W'(-e_w) : e_w[FIX_W-1:0];
      m2_sum   = {1'b0, m2_ff} + (M2_W+1)'(acc[UW-1:FRAC_BITS]);
      m2_sat   = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
      est_sum  = (M2_W+1)'(mean_ff) + (M2_W+1)'(q);
      est_raw  = (est_sum > (M2_W+1)'(FIX_MAX)) ? FIX_MAX : est_sum[FIX_W-1:0];
      floor_fx = {floor_usec, {FRAC_BITS{1'b0}}};
      restart  = cnt_ff >= restart_after;
      sleep    = !tl_ff[TL_W-1] &&
                 ({tl_ff[TL_W-2:0], {FRAC_BITS{1'b0}}} > (TL_W-1+FRAC_BITS)'(est_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = (op == OP_OBSERVE) ? ST_DIV_MEAN : ST_DECIDE;
         end
         ST_DIV_MEAN: if (it_done) state_in = ST_MUL_T;
         ST_MUL_T:    if (it_done) state_in = ST_DIV_VAR;
         ST_DIV_VAR:  if (it_done) state_in = ST_SQRT;
         ST_SQRT:     if (it_done) state_in = restart ? ST_MUL_R : ST_DECIDE;
         ST_MUL_R:    if (it_done) state_in = ST_DECIDE;
         ST_DECIDE:   if (out_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // unit commands and handshake outputs
   always_comb begin
      cmd.start = 1'b0;
      cmd.mode  = MODE_MUL;
      x_cmd     = '0;
      b_cmd     = '0;
      idle      = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle      = 1'b1;
            cmd.start = req_accept && (op == OP_OBSERVE);
            cmd.mode  = MODE_DIV;
            x_cmd     = {M2_W'(delta[FIX_W] ? FIX_W'(-delta) : delta[FIX_W-1:0]),
                         {(XW-M2_W){1'b0}}};
            b_cmd     = FIX_W'(sample_ff + CNT_W'(1));
         end
         ST_DIV_MEAN: begin
            cmd.start = it_done;
            cmd.mode  = MODE_MUL;
            x_cmd     = {ae, {(XW-FIX_W){1'b0}}};
            b_cmd     = ad_ff;
         end
         ST_MUL_T: begin
            cmd.start = it_done;
            cmd.mode  = MODE_DIV;
            x_cmd     = {m2_sat, {(XW-M2_W){1'b0}}};
            b_cmd     = FIX_W'(sample_ff);
         end
         ST_DIV_VAR: begin
            cmd.start = it_done;
            cmd.mode  = MODE_SQRT;
            x_cmd     = XW'({q, {FRAC_BITS{1'b0}}});
         end
         ST_SQRT: begin
            cmd.start = it_done && restart;
            cmd.mode  = MODE_MUL;
            x_cmd     = {ad_ff, {(XW-FIX_W){1'b0}}};
            b_cmd     = ad_ff;
         end
         ST_MUL_R: begin
            cmd.start = 1'b0;
         end
         ST_DECIDE: begin
            out_load = out_ready;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   // statistics datapath
   always_comb begin
      tl_in     = tl_ff;
      mean_in   = mean_ff;
      m2_in     = m2_ff;
      sample_in = sample_ff;
      cnt_in    = cnt_ff;
      est_in    = est_ff;
      obs_fx_in = obs_fx_ff;
      ad_in     = ad_ff;
      dneg_in   = dneg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (op == OP_REQUEST) begin
                  tl_in = TL_W'(requested_usec);
               end else begin
                  tl_in     = (tl_sub[TL_W] != tl_sub[TL_W-1]) ?
                              {1'b1, {(TL_W-1){1'b0}}} : tl_sub[TL_W-1:0];
                  cnt_in    = sample_ff + CNT_W'(1);
                  obs_fx_in = obs_fx;
                  dneg_in   = delta[FIX_W];
                  ad_in     = delta[FIX_W] ? FIX_W'(-delta) : delta[FIX_W-1:0];
               end
            end
         end
         ST_DIV_MEAN: if (it_done) mean_in = mean_new;
         ST_MUL_T:    if (it_done) m2_in = m2_sat;
         ST_SQRT: begin
            if (it_done) begin
               est_in = (est_raw > floor_fx) ? est_raw : floor_fx;
               if (!restart) sample_in = cnt_ff;
            end
         end
         ST_MUL_R: begin
            if (it_done) begin
               m2_in     = M2_W'(acc[UW-1:FRAC_BITS]);
               sample_in = CNT_W'(1);
            end
         end
         default: begin
            tl_in = tl_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tl_ff     <= '0;
         mean_ff   <= START_FIX;
         m2_ff     <= '0;
         sample_ff <= CNT_W'(1);
         est_ff    <= START_FIX;
      end else begin
         state_ff  <= state_in;
         tl_ff     <= tl_in;
         mean_ff   <= mean_in;
         m2_ff     <= m2_in;
         sample_ff <= sample_in;
         est_ff    <= est_in;
      end
      cnt_ff    <= cnt_in;
      obs_fx_ff <= obs_fx_in;
      ad_ff     <= ad_in;
      dneg_ff   <= dneg_in;
   end

   assign action        = sleep ? ACT_SLEEP : ACT_SPIN;
   assign spin_usec     = (sleep || tl_ff[TL_W-1]) ? '0 : tl_ff[REQ_W-1:0];
   assign estimate_usec = est_ff[FIX_W-1:FRAC_BITS];

`ifndef SYNTH
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      it_done |-> (state_ff == ST_DIV_MEAN || state_ff == ST_MUL_T ||
                   state_ff == ST_DIV_VAR || state_ff == ST_SQRT ||
                   state_ff == ST_MUL_R))
      else $error("unit finished outside a wait state");
   a_sample_live: assert property (@(posedge clock) disable iff (reset)
      sample_ff != '0)
      else $error("sample count is zero");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE)
      else $error("beat taken while busy");
   a_decide_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && out_ready) |=> state_ff == ST_IDLE)
      else $error("result not released");
`endif

endmodule
`default_nettype wire

/* rtl/core/precise_sleep_estimator.sv */
// a request beat goes to the decide state and is loaded into the result register once the
// output is free; an observation beat runs mean divide, product, variance divide and square
// root through one shared add/subtract unit, and a restart adds a second product
// after the square root, before the decide state
// one beat in work at a time: the next beat is taken the cycle after the result is loaded
// reset is synchronous: control state, settings and statistics return to their start values at once
`default_nettype none
module precise_sleep_estimator
   import pse_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 req_tvalid,
   output logic                       req_tready,
   input  wire  logic                 req_tuser,  // op
   input  wire  logic [47:0]          req_tdata,  // requested_usec, observed_usec
   output logic                       rsp_tvalid,
   input  wire  logic                 rsp_tready,
   output logic                       rsp_tuser,  // action
   output logic [47:0]                rsp_tdata,  // spin_usec, estimate_usec
   input  wire  logic                 csr_valid,
   output logic                       csr_ready,
   input  wire  logic [CSR_IDX_W-1:0] csr_index,
   input  wire  logic [USEC_W-1:0]    csr_wdata
);

   logic [USEC_W-1:0] floor_ff, floor_in;
   logic [USEC_W-1:0] clamp_ff, clamp_in;
   logic [CNT_W-1:0]  restart_ff, restart_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              action_ff;
   logic [REQ_W-1:0]  spin_ff;
   logic [USEC_W-1:0] est_usec_ff;

   logic              idle, out_load, out_ready, req_accept;
   logic              action;
   logic [REQ_W-1:0]  spin_usec;
   logic [USEC_W-1:0] estimate_usec;

   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign req_accept = req_tvalid & idle;
   assign out_ready  = !rsp_valid_ff || rsp_tready;

   pse_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .op             (req_tuser),
      .requested_usec (req_tdata[REQ_W-1:0]),
      .observed_usec  (req_tdata[REQ_W+USEC_W-1:REQ_W]),
      .floor_usec     (floor_ff),
      .clamp_usec     (clamp_ff),
      .restart_after  (restart_ff),
      .out_ready      (out_ready),
      .idle           (idle),
      .out_load       (out_load),
      .action         (action),
      .spin_usec      (spin_usec),
      .estimate_usec  (estimate_usec)
   );

   always_comb begin
      floor_in   = floor_ff;
      clamp_in   = clamp_ff;
      restart_in = restart_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FLOOR:   floor_in   = csr_wdata;
            CSR_CLAMP:   clamp_in   = csr_wdata;
            CSR_RESTART: restart_in = csr_wdata[CNT_W-1:0];
            default:     floor_in   = floor_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= FLOOR_RST;
         clamp_ff     <= CLAMP_RST;
         restart_ff   <= RESTART_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         floor_ff     <= floor_in;
         clamp_ff     <= clamp_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         action_ff   <= action;
         spin_ff     <= spin_usec;
         est_usec_ff <= estimate_usec;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = action_ff;
   assign rsp_tdata  = {4'b0, est_usec_ff, spin_ff};

endmodule
`default_nettype wire

/* verif/precise_sleep_estimator_tb.sv */
// self-checking testbench for precise_sleep_estimator: stream stimulus with bursts and
// stalls, a scoreboard class that predicts each answer and checks results in order
// depends on pse_pkg and the precise_sleep_estimator rtl
`timescale 1ns / 100ps
`default_nettype none
module precise_sleep_estimator_tb
   import pse_pkg::*;
();

   localparam int FB = FRAC_BITS_DEF;
   localparam logic [63:0] FIX_TOP = (64'd1 << (20 + FB)) - 1;
   localparam longint TL_FLOOR = -(64'sd1 <<< 25);

   typedef struct {
      logic              act;
      logic [REQ_W-1:0]  spin;
      logic [USEC_W-1:0] est;
   } answer_type;

   class sleep_scoreboard;
      logic [USEC_W-1:0] floor_usec;
      logic [USEC_W-1:0] clamp_usec;
      logic [CNT_W-1:0]  restart_cnt;
      longint            left_usec;
      logic [63:0]       mean_fx;
      logic [63:0]       spread_fx;
      int                count;
      logic [63:0]       estimate_fx;
      answer_type        expected_q[$];
      int                mismatches;
      int                spins;

      function new();
         floor_usec  = FLOOR_RST;
         clamp_usec  = CLAMP_RST;
         restart_cnt = RESTART_RST;
         left_usec   = 0;
         mean_fx     = 64'(START_USEC) << FB;
         spread_fx   = '0;
         count       = 1;
         estimate_fx = 64'(START_USEC) << FB;
         mismatches  = 0;
         spins       = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [USEC_W-1:0] val);
         case (idx)
            CSR_FLOOR: begin
               floor_usec = val;
            end
            CSR_CLAMP: begin
               clamp_usec = val;
            end
            CSR_RESTART: begin
               restart_cnt = val[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [63:0] root_floor(logic [127:0] v);
         logic [63:0] r;
         logic [63:0] c;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
         end
         return r;
      endfunction

      function void observe(logic [63:0] obs);
         logic [63:0]  obs_fx;
         longint       delta;
         longint       step;
         longint       mean_next;
         longint       err;
         logic [63:0]  ad;
         logic [63:0]  ae;
         logic [127:0] prod;
         logic [64:0]  total;
         logic [63:0]  variance;
         logic [63:0]  sd;
         logic [63:0]  est;
         logic [63:0]  floor_fx;
         int           cnt;
         obs_fx = obs << FB;
         left_usec = left_usec - longint'(obs);
         if (left_usec < TL_FLOOR) left_usec = TL_FLOOR;
         cnt = count + 1;
         delta = longint'(obs_fx) - longint'(mean_fx);
         step = delta / longint'(cnt);
         mean_next = longint'(mean_fx) + step;
         if (mean_next < 0) mean_next = 0;
         if (64'(mean_next) > FIX_TOP) mean_next = longint'(FIX_TOP);
         mean_fx = 64'(mean_next);
         err = longint'(obs_fx) - mean_next;
         ad = 64'(delta < 0 ? -delta : delta);
         ae = 64'(err < 0 ? -err : err);
         prod = ({64'd0, ad} * {64'd0, ae}) >> FB;
         total = {1'b0, spread_fx} + {1'b0, prod[63:0]};
         spread_fx = total[64] ? '1 : total[63:0];
         variance = spread_fx / 64'(cnt - 1);
         sd = root_floor({64'd0, variance} << FB);
         est = (sd > FIX_TOP - mean_fx) ? FIX_TOP : mean_fx + sd;
         floor_fx = 64'(floor_usec) << FB;
         estimate_fx = (est > floor_fx) ? est : floor_fx;
         if (cnt >= int'(restart_cnt)) begin
            count = 1;
            prod = ({64'd0, ad} * {64'd0, ad}) >> FB;
            spread_fx = prod[63:0];
         end else begin
            count = cnt;
         end
      endfunction

      function void note_beat(logic op, logic [REQ_W-1:0] req, logic [USEC_W-1:0] obs);
         answer_type a;
         if (op == OP_REQUEST) begin
            left_usec = longint'(req);
         end else begin
            observe(64'((obs > clamp_usec) ? clamp_usec : obs));
         end
         if (left_usec >= 0 && (64'(left_usec) << FB) > estimate_fx) begin
            a.act  = ACT_SLEEP;
            a.spin = '0;
         end else begin
            a.act  = ACT_SPIN;
            a.spin = (left_usec > 0) ? REQ_W'(left_usec) : '0;
         end
         a.est = USEC_W'(estimate_fx >> FB);
         expected_q.push_back(a);
      endfunction

      function void check_beat(logic act, logic [REQ_W-1:0] spin, logic [USEC_W-1:0] est);
         answer_type a;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: act %0b spin %0d est %0d",
                                           act, spin, est);
            return;
         end
         a = expected_q.pop_front();
         if (act == ACT_SPIN) spins++;
         if (act !== a.act || spin !== a.spin || est !== a.est) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: act %0b/%0b spin %0d/%0d est %0d/%0d (exp/got)",
                        $realtime, a.act, act, a.spin, spin, a.est, est);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic                 req_tuser;
   logic [47:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic                 rsp_tuser;
   logic [47:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [USEC_W-1:0]    csr_wdata;

   sleep_scoreboard sb;
   int burst_left;
   int n_requests;
   int n_observations;
   int n_writes;

   precise_sleep_estimator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver stall pattern: always ready, random, periodic or seldom ready, picked anew at random
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 400 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = (cyc % 7) < 3;
            default: rsp_tready = ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_beat(rsp_tuser, rsp_tdata[23:0], rsp_tdata[43:24]);
      end
   end

   task automatic send_beat(input logic op, input logic [REQ_W-1:0] r,
                            input logic [USEC_W-1:0] o);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {4'h0, o, r};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(op, r, o);
      if (op == OP_REQUEST) n_requests++;
      else n_observations++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [USEC_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      n_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_regs(input logic [USEC_W-1:0] fl, input logic [USEC_W-1:0] cl,
                           input logic [CNT_W-1:0] rs);
      wait_idle();
      write_reg(CSR_FLOOR, fl);
      write_reg(CSR_CLAMP, cl);
      // upper bits beyond the restart width are junk
      write_reg(CSR_RESTART, {6'($urandom), rs});
   endtask

   // one wait: a request followed by a few coarse sleep reports
   task automatic random_wait(input int wide);
      logic [REQ_W-1:0] r;
      int n;
      r = wide ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 60000));
      send_beat(OP_REQUEST, r, USEC_W'($urandom));
      n = $urandom_range(1, 10);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(OP_OBSERVE, REQ_W'($urandom), USEC_W'($urandom));
         else
            send_beat(OP_OBSERVE, REQ_W'($urandom), USEC_W'($urandom_range(800, 3000)));
      end
   endtask

   task automatic random_phase(input int beats, input int wide);
      int start;
      start = n_requests + n_observations;
      while (n_requests + n_observations - start < beats) begin
         if ($urandom_range(0, 7) == 0)
            send_beat(OP_OBSERVE, REQ_W'($urandom), USEC_W'($urandom));
         else
            random_wait(wide);
      end
   endtask

   initial begin
      sb = new();
      burst_left = 0;
      n_requests = 0;
      n_observations = 0;
      n_writes = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = OP_REQUEST;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FLOOR;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, observation outside a wait, bit patterns
      send_beat(OP_REQUEST, '0, '0);
      send_beat(OP_OBSERVE, '0, '0);
      send_beat(OP_OBSERVE, '1, '1);
      send_beat(OP_REQUEST, '1, '1);
      send_beat(OP_OBSERVE, 24'h555555, 20'hAAAAA);
      send_beat(OP_OBSERVE, 24'hAAAAAA, 20'h55555);
      send_beat(OP_REQUEST, 24'd1500, '0);
      send_beat(OP_REQUEST, 24'd2000, '0);
      send_beat(OP_OBSERVE, '0, 20'd1000);

      // no clamp: drive time left far below zero, spread the statistics
      set_regs('0, '1, 14'h3FFF);
      send_beat(OP_REQUEST, '0, '0);
      for (int k = 0; k < 40; k++) send_beat(OP_OBSERVE, '0, k[0] ? '1 : '0);
      send_beat(OP_REQUEST, '1, '0);
      random_phase(180, 1);

      // clamp zero, restart every observation, floor at top
      set_regs('1, '0, '0);
      send_beat(OP_OBSERVE, '0, '1);
      random_phase(180, 1);

      set_regs(20'd500, 20'd3000, 14'd1);
      random_phase(200, 0);

      set_regs(FLOOR_RST, CLAMP_RST, 14'd2);
      random_phase(200, 0);

      set_regs(20'd800, 20'd20000, 14'd200);
      random_phase(250, 0);

      // restart lowered below the running count
      set_regs(20'd800, 20'd20000, 14'd3);
      random_phase(200, 0);

      set_regs(20'($urandom_range(0, 4000)), 20'($urandom_range(1, 1048575)),
               14'($urandom_range(2, 16383)));
      random_phase(250, 1);

      // floor change takes effect only at the next observation
      set_regs(20'd5000, CLAMP_RST, RESTART_RST);
      send_beat(OP_REQUEST, 24'd4000, '0);
      send_beat(OP_OBSERVE, '0, 20'd1000);

      wait_idle();
      $display("covered %0d requests, %0d observations, %0d spin answers, %0d register writes",
               n_requests, n_observations, sb.spins, n_writes);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
